### src/ses_pkg.sv
package ses_pkg;

    // Odd Taylor coefficients of sin(pi/2 * x) for x in Q30.
    localparam logic [30:0] K1 = 31'd1686629713;
    localparam logic [30:0] K3 = 31'd693598668;
    localparam logic [30:0] K5 = 31'd85569306;
    localparam logic [30:0] K7 = 31'd5026994;
    localparam logic [30:0] K9 = 31'd172272;

    localparam logic [30:0] Q30_ONE  = 31'd1073741824;
    localparam logic [62:0] Q30_HALF = 63'd536870912;

    // Latitude to turns: round(mag * 2^23 / 45), split into a whole part and a
    // remainder part that is divided by a reciprocal multiply.
    localparam logic [31:0] LAT_BASE  = 32'd186413;
    localparam logic [17:0] LAT_REM   = 18'd23;
    localparam logic [17:0] LAT_HALF  = 18'd22;
    localparam logic [18:0] LAT_RECIP = 19'd372828;
    localparam int          LAT_SHIFT = 24;

    // Hour angle to turns: round(mag * 2^21 / 3).
    localparam logic [31:0] HA_BASE  = 32'd699050;
    localparam logic [14:0] HA_RECIP = 15'd21846;
    localparam int          HA_SHIFT = 16;

    // Day phase to turns: round(mag * 2^32 / 365).
    localparam logic [31:0] DAY_BASE   = 32'd11767033;
    localparam logic [16:0] DAY_REM    = 17'd251;
    localparam logic [16:0] DAY_HALF   = 17'd182;
    localparam logic [15:0] DAY_RECIP  = 16'd45965;
    localparam int          DAY_SHIFT  = 24;
    localparam logic [10:0] DAY_OFFSET = 11'd80;

    // Declination: round(s * 469 / 1800), s the Q30 sine of the day phase.
    localparam logic [30:0] DECL_RECIP = 31'd1119077589;
    localparam logic [12:0] DECL_MUL   = 13'd469;
    localparam logic [12:0] DECL_HALF  = 13'd900;
    localparam logic [12:0] DECL_DIV   = 13'd1800;
    localparam logic [12:0] DECL_DIV2  = 13'd3600;

    // Q30 product rounded half up; both operands stay below 2^31 and the
    // result below 2^31.
    function automatic logic [30:0] mulq30(input logic [30:0] a, input logic [30:0] b);
        logic [62:0] p;
        p = 63'(a) * 63'(b) + Q30_HALF;
        return p[60:30];
    endfunction

endpackage

### src/ses_in_if.sv
interface ses_in_if;
    logic               valid;
    logic               ready;
    logic        [8:0]  day_of_year;
    logic signed [13:0] latitude;
    logic signed [12:0] solar_hours;

    modport source (output valid, output day_of_year, output latitude,
                    output solar_hours, input ready);
    modport sink   (input valid, input day_of_year, input latitude,
                    input solar_hours, output ready);
endinterface

### src/ses_out_if.sv
interface ses_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] elevation_sine;

    modport source (output valid, output elevation_sine, input ready);
    modport sink   (input valid, input elevation_sine, output ready);
endinterface

### src/ses_sine.sv
// Six stage sine of a binary angle, Q2.30 result, advancing whenever i_ce is high.
module ses_sine import ses_pkg::*; #(
    parameter int ANGLE_BITS = 18
) (
    input  logic                  i_clk,
    input  logic                  i_ce,
    input  logic [ANGLE_BITS-1:0] i_phase,
    output logic signed [31:0]    o_sine
);

    localparam int DROP = 32 - ANGLE_BITS;

    logic [31:0] n_p;
    logic [30:0] n_x;
    logic [31:0] n_y;

    logic [30:0] r_x  [0:4];
    logic [30:0] r_x2 [0:3];
    logic        r_ng [0:4];
    logic [30:0] r_acc[0:3];
    logic signed [31:0] r_y;

    // The quadrant folds the phase onto the first quarter wave.
    assign n_p = 32'(i_phase) << DROP;
    assign n_x = n_p[30] ? (Q30_ONE - {1'b0, n_p[29:0]}) : {1'b0, n_p[29:0]};
    assign n_y = 32'(mulq30(r_acc[3], r_x[4]));

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x[0]   <= n_x;
            r_x2[0]  <= mulq30(n_x, n_x);
            r_ng[0]  <= n_p[31];
            r_acc[0] <= K7 - mulq30(K9, r_x2[0]);
            r_acc[1] <= K5 - mulq30(r_acc[0], r_x2[1]);
            r_acc[2] <= K3 - mulq30(r_acc[1], r_x2[2]);
            r_acc[3] <= K1 - mulq30(r_acc[2], r_x2[3]);
            for (int i = 1; i < 5; i++) begin
                r_x[i]  <= r_x[i-1];
                r_ng[i] <= r_ng[i-1];
            end
            for (int i = 1; i < 4; i++) begin
                r_x2[i] <= r_x2[i-1];
            end
            r_y <= r_ng[4] ? -$signed(n_y) : $signed(n_y);
        end
    end

    assign o_sine = r_y;

endmodule

### src/solar_elevation_sine_core.sv
// Sine of the solar elevation angle. Each input beat carries a day of the year, a latitude in
// 1/64 degree and a solar time in 1/256 hour from noon; one output beat returns
// sin(lat)sin(decl) + cos(lat)cos(decl)cos(hour angle) as signed Q1.15, saturated at +1 and -1,
// with the declination taken from the Cooper formula. All angles are binary angles of
// ANGLE_BITS bits. The block takes one beat every clock cycle while it is not stalled, and a beat
// passes from acceptance to the output register through the chain of the day sine, the declination
// scaling, the declination sine and cosine and the final products. The whole pipeline stalls
// together only when the two-entry output buffer is full, so a result that waits at the output
// does not stop the next beat from being taken.
module solar_elevation_sine_core import ses_pkg::*; #(
    parameter int ANGLE_BITS = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ses_in_if.sink     i_in,
    ses_out_if.source  o_out
);

    localparam int LAT  = 23;
    localparam int DLY  = 9;
    localparam int DROP = 32 - ANGLE_BITS;
    localparam logic [31:0] QHALF = (32'(1) << DROP) >> 1;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // Round a 32-bit turn phase to the binary angle width, half up, wrapping.
    function automatic logic [ANGLE_BITS-1:0] quant(input logic [31:0] p);
        logic [31:0] s;
        s = p + QHALF;
        return s[31 -: ANGLE_BITS];
    endfunction

    // Output register with a skid entry behind it.
    logic               r_out_v, r_skid_v;
    logic signed [15:0] r_out_d, r_skid_d;
    logic               w_push, w_pop;

    // The pipeline advances whenever the output buffer has room for one more beat.
    logic adv;
    assign adv = !r_skid_v;
    assign i_in.ready = adv;

    logic r_v [0:LAT-1];

    // Stage A: magnitudes, signs and the remainder terms of the three conversions to turns.
    logic        n_lat_neg, n_ha_neg, n_day_neg;
    logic [13:0] n_lat_mag;
    logic [12:0] n_ha_mag;
    logic [8:0]  n_day_mag;
    logic [10:0] n_day_v;
    logic [17:0] n_lat_x;
    logic [13:0] n_ha_x;
    logic [16:0] n_day_x;

    logic        r_a_lat_neg, r_a_ha_neg, r_a_day_neg;
    logic [13:0] r_a_lat_mag;
    logic [12:0] r_a_ha_mag;
    logic [8:0]  r_a_day_mag;
    logic [17:0] r_a_lat_x;
    logic [13:0] r_a_ha_x;
    logic [16:0] r_a_day_x;

    always_comb begin
        n_lat_neg = i_in.latitude[13];
        n_lat_mag = n_lat_neg ? 14'(14'd0 - $unsigned(i_in.latitude)) : $unsigned(i_in.latitude);
        n_lat_x   = 18'(18'(n_lat_mag) * LAT_REM) + LAT_HALF;
        n_ha_neg  = i_in.solar_hours[12];
        n_ha_mag  = n_ha_neg ? 13'(13'd0 - $unsigned(i_in.solar_hours))
                             : $unsigned(i_in.solar_hours);
        n_ha_x    = {n_ha_mag, 1'b1};
        n_day_v   = {2'b00, i_in.day_of_year} - DAY_OFFSET;
        n_day_neg = n_day_v[10];
        n_day_mag = n_day_neg ? 9'(11'd0 - n_day_v) : n_day_v[8:0];
        n_day_x   = 17'(17'(n_day_mag) * DAY_REM) + DAY_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_lat_neg <= n_lat_neg;
            r_a_lat_mag <= n_lat_mag;
            r_a_lat_x   <= n_lat_x;
            r_a_ha_neg  <= n_ha_neg;
            r_a_ha_mag  <= n_ha_mag;
            r_a_ha_x    <= n_ha_x;
            r_a_day_neg <= n_day_neg;
            r_a_day_mag <= n_day_mag;
            r_a_day_x   <= n_day_x;
        end
    end

    // Stage B: whole part by a constant multiply, remainder part divided through a reciprocal.
    logic [36:0] n_lat_rp;
    logic [28:0] n_ha_rp;
    logic [32:0] n_day_rp;

    logic        r_b_lat_neg, r_b_ha_neg, r_b_day_neg;
    logic [31:0] r_b_lat_base, r_b_ha_base, r_b_day_base;
    logic [12:0] r_b_lat_frac;
    logic [12:0] r_b_ha_frac;
    logic [8:0]  r_b_day_frac;

    assign n_lat_rp = 37'(r_a_lat_x) * 37'(LAT_RECIP);
    assign n_ha_rp  = 29'(r_a_ha_x) * 29'(HA_RECIP);
    assign n_day_rp = 33'(r_a_day_x) * 33'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_lat_neg  <= r_a_lat_neg;
            r_b_ha_neg   <= r_a_ha_neg;
            r_b_day_neg  <= r_a_day_neg;
            r_b_lat_base <= 32'(32'(r_a_lat_mag) * LAT_BASE);
            r_b_ha_base  <= 32'(32'(r_a_ha_mag) * HA_BASE);
            r_b_day_base <= 32'(32'(r_a_day_mag) * DAY_BASE);
            r_b_lat_frac <= 13'(n_lat_rp >> LAT_SHIFT);
            r_b_ha_frac  <= 13'(n_ha_rp >> HA_SHIFT);
            r_b_day_frac <= 9'(n_day_rp >> DAY_SHIFT);
        end
    end

    // Stage C: signed turn phases, rounded to the angle width.
    logic [31:0] n_lat_q, n_ha_q, n_day_q;
    logic [ANGLE_BITS-1:0] r_c_lat, r_c_ha, r_c_day;

    always_comb begin
        n_lat_q = r_b_lat_base + 32'(r_b_lat_frac);
        n_ha_q  = r_b_ha_base + 32'(r_b_ha_frac);
        n_day_q = r_b_day_base + 32'(r_b_day_frac);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_lat <= quant(r_b_lat_neg ? (32'd0 - n_lat_q) : n_lat_q);
            r_c_ha  <= quant(r_b_ha_neg ? (32'd0 - n_ha_q) : n_ha_q);
            r_c_day <= quant(r_b_day_neg ? (32'd0 - n_day_q) : n_day_q);
        end
    end

    // Sine of the day phase.
    logic signed [31:0] w_sd_day;

    ses_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_day (
        .i_clk   (i_clk),
        .i_ce    (adv),
        .i_phase (r_c_day),
        .o_sine  (w_sd_day)
    );

    // Declination scaling. The reciprocal estimate falls short by at most two, which the low
    // thirteen bits of the remainder settle.
    logic        n_d_neg;
    logic [30:0] n_d_mag;
    logic [61:0] n_d_prod;

    logic        r_d1_neg, r_d2_neg;
    logic [29:0] r_d1_qe, r_d2_qe;
    logic [12:0] r_d1_nlow, r_d2_rem;
    logic [29:0] n_d_q;
    logic [31:0] n_d_t;
    logic [ANGLE_BITS-1:0] r_decl;

    always_comb begin
        n_d_neg  = w_sd_day[31];
        n_d_mag  = n_d_neg ? 31'(32'd0 - $unsigned(w_sd_day)) : w_sd_day[30:0];
        n_d_prod = 62'(n_d_mag) * 62'(DECL_RECIP);
        if (r_d2_rem >= DECL_DIV2) begin
            n_d_q = r_d2_qe + 30'd2;
        end else if (r_d2_rem >= DECL_DIV) begin
            n_d_q = r_d2_qe + 30'd1;
        end else begin
            n_d_q = r_d2_qe;
        end
        n_d_t = r_d2_neg ? (32'd0 - 32'(n_d_q)) : 32'(n_d_q);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1_neg  <= n_d_neg;
            r_d1_qe   <= n_d_prod[61:32];
            r_d1_nlow <= 13'(n_d_mag[12:0] * DECL_MUL) + DECL_HALF;
            r_d2_neg  <= r_d1_neg;
            r_d2_qe   <= r_d1_qe;
            r_d2_rem  <= r_d1_nlow - 13'(r_d1_qe[12:0] * DECL_DIV);
            r_decl    <= quant(n_d_t);
        end
    end

    // Latitude and hour angle wait for the declination.
    logic [ANGLE_BITS-1:0] r_dly_lat [0:DLY-1];
    logic [ANGLE_BITS-1:0] r_dly_ha  [0:DLY-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly_lat[0] <= r_c_lat;
            r_dly_ha[0]  <= r_c_ha;
            for (int i = 1; i < DLY; i++) begin
                r_dly_lat[i] <= r_dly_lat[i-1];
                r_dly_ha[i]  <= r_dly_ha[i-1];
            end
        end
    end

    logic signed [31:0] w_sl, w_cl, w_sd, w_cd, w_ch;

    ses_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_decl (
        .i_clk(i_clk), .i_ce(adv), .i_phase(r_decl), .o_sine(w_sd)
    );
    ses_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_decl (
        .i_clk(i_clk), .i_ce(adv), .i_phase(r_decl + QUARTER), .o_sine(w_cd)
    );
    ses_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_lat (
        .i_clk(i_clk), .i_ce(adv), .i_phase(r_dly_lat[DLY-1]), .o_sine(w_sl)
    );
    ses_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_lat (
        .i_clk(i_clk), .i_ce(adv), .i_phase(r_dly_lat[DLY-1] + QUARTER), .o_sine(w_cl)
    );
    ses_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ha (
        .i_clk(i_clk), .i_ce(adv), .i_phase(r_dly_ha[DLY-1] + QUARTER), .o_sine(w_ch)
    );

    // Combination: two products, the rounded cosine product times the hour-angle cosine, the
    // sum, then rounding to Q15 half away from zero with saturation.
    logic signed [63:0] r_f1_p1, r_f1_p2, r_f2_p1, r_f3_p1, r_f3_p3;
    logic signed [31:0] r_f1_ch, r_f2_ch, r_f2_cc;
    logic signed [64:0] r_f4_sum;
    logic signed [15:0] r_f5_res;

    logic [63:0] n_cc_mag;
    logic [33:0] n_cc_rnd;
    logic [64:0] n_s_mag;
    logic [19:0] n_s_rnd;
    logic signed [15:0] n_res;

    always_comb begin
        n_cc_mag = r_f1_p2[63] ? (64'd0 - $unsigned(r_f1_p2)) : $unsigned(r_f1_p2);
        n_cc_rnd = 34'((n_cc_mag + (64'd1 << 29)) >> 30);
        n_s_mag  = r_f4_sum[64] ? (65'd0 - $unsigned(r_f4_sum)) : $unsigned(r_f4_sum);
        n_s_rnd  = 20'((n_s_mag + (65'd1 << 44)) >> 45);
        if (r_f4_sum[64]) begin
            n_res = (n_s_rnd > 20'd32768) ? -16'sd32768 : 16'(20'd0 - n_s_rnd);
        end else begin
            n_res = (n_s_rnd > 20'd32767) ? 16'sd32767 : 16'(n_s_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_p1  <= 64'(w_sl) * 64'(w_sd);
            r_f1_p2  <= 64'(w_cl) * 64'(w_cd);
            r_f1_ch  <= w_ch;
            r_f2_p1  <= r_f1_p1;
            r_f2_ch  <= r_f1_ch;
            r_f2_cc  <= r_f1_p2[63] ? 32'(34'd0 - n_cc_rnd) : 32'(n_cc_rnd);
            r_f3_p1  <= r_f2_p1;
            r_f3_p3  <= 64'(r_f2_cc) * 64'(r_f2_ch);
            r_f4_sum <= 65'(r_f3_p1) + 65'(r_f3_p3);
            r_f5_res <= n_res;
        end
    end

    // Valid bits travel alongside the data, one per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= i_in.valid;
            for (int i = 1; i < LAT; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    // The skid entry fills only when a finished beat arrives while the output is held, and
    // the pipeline stalls until it drains.
    assign w_push = adv && r_v[LAT-1];
    assign w_pop  = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) begin
                r_out_d  <= r_skid_d;
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v || w_pop) begin
                r_out_v <= 1'b1;
                r_out_d <= r_f5_res;
            end else begin
                r_skid_v <= 1'b1;
                r_skid_d <= r_f5_res;
            end
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.elevation_sine = r_out_d;

    // The skid entry is never occupied behind an empty output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds a beat while the output is empty");

    // The skid entry only fills when the output was held by the sink.
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_out.ready))
        else $error("skid entry filled without a stalled output");

    // A finished beat leaving the pipeline always leaves the output valid next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_out_v)
        else $error("finished beat lost at the output");

endmodule
